// ===== sv/bsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsd_pkg;

    // Ring depth; must be a power of two so that slot arithmetic wraps by truncation.
    localparam int DEPTH  = 16;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam logic [3:0] GSL_RESET = 4'd11;

    typedef enum logic [3:0] {
        REQ_PUSH_FRONT = 4'd0,
        REQ_PUSH_BACK  = 4'd1,
        REQ_POP_FRONT  = 4'd2,
        REQ_POP_BACK   = 4'd3,
        REQ_READ       = 4'd4,
        REQ_WRITE      = 4'd5,
        REQ_CONTAINS   = 4'd6,
        REQ_GREATER    = 4'd7,
        REQ_CLEAR      = 4'd8
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADIDX = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCAN
    } t_state;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] data;
        logic               found;
        logic [3:0]         position;
        logic [4:0]         count;
    } t_result;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_ram_req;

endpackage

`default_nettype wire

// ===== sv/bounded_sequence_deque.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bounded deque of signed 32-bit values held in a single-port ring memory of DEPTH slots,
// with push and pop at both ends, indexed read and write, a membership search, a
// first-greater search and clear. Each transfer on the request channel yields exactly one
// transfer on the result channel. A request is taken in one cycle and executed in the next;
// a read then fetches its entry from the memory, and a search reads the entries in order
// from the front until a hit or its last position (at most DEPTH entries examined), as the
// memory port delivers one entry per cycle. A new request is taken while the previous
// result still waits in the output register. The register at APB address 0 holds the last
// position examined by the first-greater search (reset 11).
module bounded_sequence_deque
    import bsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [3:0]  i_req_type,
    input  wire logic [3:0]  i_index,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [31:0]      o_data,
    output logic             o_found,
    output logic [3:0]       o_position,
    output logic [4:0]       o_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [3:0]        r_gsl;
    t_result           r_out;
    logic              r_out_valid;
    logic              c_res_ready;
    logic              c_res_valid;
    t_result           c_res;
    t_ram_req          c_ram;
    logic [DATA_W-1:0] c_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {28'd0, r_gsl} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gsl <= GSL_RESET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_gsl <= pwdata[3:0];
        end
    end

    assign c_res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_res_ready) begin
            r_out_valid <= c_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_res_ready && c_res_valid) begin
            r_out <= c_res;
        end
    end

    bsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_gsl       (r_gsl),
        .i_res_ready (c_res_ready),
        .o_res_valid (c_res_valid),
        .o_res       (c_res),
        .o_ram       (c_ram),
        .i_rdata     (c_rdata)
    );

    bsd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (c_ram.en),
        .i_we    (c_ram.we),
        .i_addr  (c_ram.addr),
        .i_wdata (c_ram.wdata),
        .o_rdata (c_rdata)
    );

    assign o_valid    = r_out_valid;
    assign o_status   = r_out.status;
    assign o_data     = r_out.data;
    assign o_found    = r_out.found;
    assign o_position = r_out.position;
    assign o_count    = r_out.count;

endmodule

`default_nettype wire

// ===== sv/bsd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds its value until the next read.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/bsd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsd_ctrl
    import bsd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [3:0]        i_req_type,
    input  wire logic [3:0]        i_index,
    input  wire logic [31:0]       i_value,
    input  wire logic [3:0]        i_gsl,
    input  wire logic              i_res_ready,
    output logic                   o_res_valid,
    output t_result                o_res,
    output t_ram_req               o_ram,
    input  wire logic [DATA_W-1:0] i_rdata
);

    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_front, n_front;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [3:0]         r_req;
    logic [3:0]         r_index;
    logic signed [31:0] r_value;
    logic [SLOT_W-1:0]  r_pos, n_pos;
    logic [SLOT_W-1:0]  r_last, n_last;

    logic              c_full;
    logic              c_empty;
    logic              c_idx_ok;
    logic              c_hit;
    logic              c_end;
    logic [CNT_W-1:0]  c_cnt_m1;
    logic [SLOT_W-1:0] c_idx_slot;

    assign c_full     = (r_count == CNT_W'(DEPTH));
    assign c_empty    = (r_count == '0);
    assign c_idx_ok   = (32'(r_index) < 32'(r_count));
    assign c_idx_slot = r_front + SLOT_W'(r_index);
    assign c_cnt_m1   = r_count - CNT_W'(1);
    assign c_hit      = (r_req == REQ_CONTAINS) ? (i_rdata == r_value)
                                                : ($signed(i_rdata) > r_value);
    assign c_end      = c_hit || (r_pos == r_last);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_req)
                    REQ_READ: begin
                        if (c_idx_ok) begin
                            n_state = S_READ;
                        end else if (i_res_ready) begin
                            n_state = S_IDLE;
                        end
                    end
                    REQ_CONTAINS, REQ_GREATER: begin
                        if (!c_empty) begin
                            n_state = S_SCAN;
                        end else if (i_res_ready) begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        if (i_res_ready) begin
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_READ: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (c_end && i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs, memory requests and pointer updates
    always_comb begin
        o_ready        = (r_state == S_IDLE);
        o_res_valid    = 1'b0;
        o_res.status   = ST_OK;
        o_res.data     = '0;
        o_res.found    = 1'b0;
        o_res.position = '0;
        o_res.count    = 5'(r_count);
        o_ram.en       = 1'b0;
        o_ram.we       = 1'b0;
        o_ram.addr     = c_idx_slot;
        o_ram.wdata    = r_value;
        n_front        = r_front;
        n_count        = r_count;
        n_pos          = r_pos;
        n_last         = r_last;

        unique case (r_state)
            S_IDLE: begin
            end
            S_EXEC: begin
                case (r_req)
                    REQ_PUSH_FRONT: begin
                        o_res_valid = 1'b1;
                        if (c_full) begin
                            o_res.status = ST_FULL;
                        end else if (i_res_ready) begin
                            o_ram.en   = 1'b1;
                            o_ram.we   = 1'b1;
                            o_ram.addr = r_front - SLOT_W'(1);
                            n_front    = r_front - SLOT_W'(1);
                            n_count    = r_count + CNT_W'(1);
                        end
                        if (!c_full) begin
                            o_res.count = 5'(r_count + CNT_W'(1));
                        end
                    end
                    REQ_PUSH_BACK: begin
                        o_res_valid = 1'b1;
                        if (c_full) begin
                            o_res.status = ST_FULL;
                        end else begin
                            o_res.count = 5'(r_count + CNT_W'(1));
                            if (i_res_ready) begin
                                o_ram.en   = 1'b1;
                                o_ram.we   = 1'b1;
                                o_ram.addr = r_front + SLOT_W'(r_count);
                                n_count    = r_count + CNT_W'(1);
                            end
                        end
                    end
                    REQ_POP_FRONT, REQ_POP_BACK: begin
                        o_res_valid = 1'b1;
                        if (c_empty) begin
                            o_res.status = ST_EMPTY;
                        end else begin
                            o_res.count = 5'(c_cnt_m1);
                            if (i_res_ready) begin
                                n_count = c_cnt_m1;
                                if (r_req == REQ_POP_FRONT) begin
                                    n_front = r_front + SLOT_W'(1);
                                end
                            end
                        end
                    end
                    REQ_READ: begin
                        if (c_idx_ok) begin
                            o_ram.en = 1'b1;
                        end else begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_BADIDX;
                        end
                    end
                    REQ_WRITE: begin
                        o_res_valid = 1'b1;
                        if (!c_idx_ok) begin
                            o_res.status = ST_BADIDX;
                        end else if (i_res_ready) begin
                            o_ram.en = 1'b1;
                            o_ram.we = 1'b1;
                        end
                    end
                    REQ_CONTAINS, REQ_GREATER: begin
                        if (c_empty) begin
                            o_res_valid = 1'b1;
                        end else begin
                            o_ram.en   = 1'b1;
                            o_ram.addr = r_front;
                            n_pos      = '0;
                            if (r_req == REQ_GREATER && 32'(i_gsl) < 32'(c_cnt_m1)) begin
                                n_last = SLOT_W'(i_gsl);
                            end else begin
                                n_last = SLOT_W'(c_cnt_m1);
                            end
                        end
                    end
                    REQ_CLEAR: begin
                        o_res_valid = 1'b1;
                        o_res.count = '0;
                        if (i_res_ready) begin
                            n_front = '0;
                            n_count = '0;
                        end
                    end
                    default: begin
                        o_res_valid = 1'b1;
                    end
                endcase
            end
            S_READ: begin
                o_res_valid = 1'b1;
                o_res.data  = i_rdata;
            end
            S_SCAN: begin
                // Read data belongs to position r_pos; fetch the next one unless done.
                if (c_end) begin
                    o_res_valid = 1'b1;
                    o_res.found = c_hit;
                    if (c_hit && r_req == REQ_GREATER) begin
                        o_res.position = 4'(r_pos);
                    end
                end else begin
                    o_ram.en   = 1'b1;
                    o_ram.addr = r_front + r_pos + SLOT_W'(1);
                    n_pos      = r_pos + SLOT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_req   <= i_req_type;
            r_index <= i_index;
            r_value <= i_value;
        end
        r_pos  <= n_pos;
        r_last <= n_last;
    end

endmodule

`default_nettype wire

// ===== bench/tb_bounded_sequence_deque.sv =====
`timescale 1ns / 1ps

module tb_bounded_sequence_deque;
    import bsd_pkg::*;

    localparam int LIMIT_CYCLES   = 400_000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [2:0] SEARCH_LAST_ADDR = 3'd0;
    localparam logic [3:0] REQ_UNUSED_LO = 4'd9;
    localparam logic [3:0] REQ_UNUSED_HI = 4'd15;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_NEG_ONE = 32'hFFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [3:0]  i_req_type;
    logic [3:0]  i_index;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [31:0] o_data;
    logic        o_found;
    logic [3:0]  o_position;
    logic [4:0]  o_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the deque, updated as each request is accepted.
    logic [31:0] shadow_slots [DEPTH];
    logic [3:0]  shadow_front;
    logic [4:0]  shadow_fill;
    logic [3:0]  shadow_search_last;

    t_result     outcomes_due [$];
    t_result     due;
    int          bad_outcomes = 0;
    int          tx_calm = 0;
    int          rx_calm = 0;
    int          rx_hold_cycles = 0;

    bounded_sequence_deque dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_index    (i_index),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_data     (o_data),
        .o_found    (o_found),
        .o_position (o_position),
        .o_count    (o_count),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 i_clk = ~i_clk;

    // Mostly random waits, with occasional runs of back-to-back transfers.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic void flag_mismatch(input string what);
        bad_outcomes++;
        if (bad_outcomes <= REPORT_LIMIT)
            $display("mismatch: %s", what);
    endfunction

    function automatic t_result deque_step(input logic [3:0] req, input logic [3:0] idx,
                                           input logic [31:0] val);
        t_result    r;
        logic [3:0] slot;
        logic [4:0] k;
        r.status   = ST_OK;
        r.data     = '0;
        r.found    = 1'b0;
        r.position = '0;
        case (req)
            REQ_PUSH_FRONT: begin
                if (shadow_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_front = shadow_front - 4'd1;
                    shadow_slots[shadow_front] = val;
                    shadow_fill++;
                end
            end
            REQ_PUSH_BACK: begin
                if (shadow_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot = shadow_front + shadow_fill[3:0];
                    shadow_slots[slot] = val;
                    shadow_fill++;
                end
            end
            REQ_POP_FRONT: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_front = shadow_front + 4'd1;
                    shadow_fill--;
                end
            end
            REQ_POP_BACK: begin
                if (shadow_fill == 0)
                    r.status = ST_EMPTY;
                else
                    shadow_fill--;
            end
            REQ_READ: begin
                if (idx >= shadow_fill) begin
                    r.status = ST_BADIDX;
                end else begin
                    slot = shadow_front + idx;
                    r.data = shadow_slots[slot];
                end
            end
            REQ_WRITE: begin
                if (idx >= shadow_fill) begin
                    r.status = ST_BADIDX;
                end else begin
                    slot = shadow_front + idx;
                    shadow_slots[slot] = val;
                end
            end
            REQ_CONTAINS: begin
                for (k = 0; k < shadow_fill && !r.found; k++) begin
                    slot = shadow_front + k[3:0];
                    if (shadow_slots[slot] == val)
                        r.found = 1'b1;
                end
            end
            REQ_GREATER: begin
                for (k = 0; k < shadow_fill && k <= {1'b0, shadow_search_last} && !r.found;
                     k++) begin
                    slot = shadow_front + k[3:0];
                    if ($signed(shadow_slots[slot]) > $signed(val)) begin
                        r.found    = 1'b1;
                        r.position = k[3:0];
                    end
                end
            end
            REQ_CLEAR: begin
                shadow_fill  = '0;
                shadow_front = '0;
            end
            default: ;
        endcase
        r.count = shadow_fill;
        return r;
    endfunction

    // Offers one request and records its outcome once the transfer has taken place.
    task automatic send_item(input logic [3:0] req, input logic [3:0] idx,
                             input logic [31:0] val);
        int gap;
        gap = draw_wait(tx_calm);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type = req;
        i_index    = idx;
        i_value    = val;
        i_valid    = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        outcomes_due.push_back(deque_step(req, idx, val));
        @(negedge i_clk);
    endtask

    task automatic drain_outcomes();
        i_valid = 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Writes the search limit with junk in the upper bits, then reads it back.
    task automatic set_search_limit(input logic [3:0] limit);
        logic [31:0] word;
        word = $urandom;
        word[3:0] = limit;
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = SEARCH_LAST_ADDR;
        pwdata  = word;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_search_last = limit;
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[3:0] !== limit)
            flag_mismatch($sformatf("search limit read back: expected %0d, got %0d",
                                    limit, prdata[3:0]));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic random_requests(input int target);
        int          taken;
        int          pick;
        logic [3:0]  req;
        logic [3:0]  idx;
        logic [3:0]  slot;
        logic [31:0] val;
        taken = 0;
        while (taken < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                req = 4'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
            else if (pick < 5)
                req = REQ_CLEAR;
            else if (pick < 33)
                req = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
            else if (pick < 47)
                req = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
            else if (pick < 62)
                req = REQ_READ;
            else if (pick < 74)
                req = REQ_WRITE;
            else if (pick < 86)
                req = REQ_CONTAINS;
            else
                req = REQ_GREATER;
            // Pushes outnumber pops, so the store climbs to full; this keeps it from staying there.
            if (shadow_fill == DEPTH && $urandom_range(0, 3) != 0) begin
                if (req == REQ_PUSH_BACK)
                    req = REQ_POP_BACK;
                else if (req == REQ_PUSH_FRONT)
                    req = REQ_POP_FRONT;
            end
            if (shadow_fill != 0 && $urandom_range(0, 6) != 0)
                idx = 4'($urandom_range(0, shadow_fill - 1));
            else
                idx = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    if (shadow_fill != 0) begin
                        slot = shadow_front + 4'($urandom_range(0, shadow_fill - 1));
                        val = shadow_slots[slot] + $urandom_range(0, 2) - 1;
                    end else begin
                        val = $urandom;
                    end
                end
                4, 5: val = $urandom_range(0, 16) - 8;
                6: begin
                    case ($urandom_range(0, 3))
                        0: val = VAL_MIN;
                        1: val = VAL_MAX;
                        2: val = '0;
                        default: val = VAL_NEG_ONE;
                    endcase
                end
                default: val = $urandom;
            endcase
            send_item(req, idx, val);
            if (req <= REQ_CLEAR)
                taken++;
        end
    endtask

    task automatic test_empty_store();
        send_item(REQ_POP_FRONT, 4'd0, 32'd0);
        send_item(REQ_POP_BACK, 4'd0, 32'd0);
        send_item(REQ_READ, 4'd0, 32'd0);
        send_item(REQ_WRITE, 4'd0, 32'd5);
        send_item(REQ_CONTAINS, 4'd0, 32'd0);
        send_item(REQ_GREATER, 4'd0, VAL_MIN);
        send_item(REQ_UNUSED_LO, 4'd15, VAL_NEG_ONE);
        send_item(REQ_UNUSED_HI, 4'd0, 32'd0);
        drain_outcomes();
    endtask

    task automatic test_mixed_contents();
        send_item(REQ_PUSH_BACK, 4'd0, VAL_MAX);
        send_item(REQ_PUSH_FRONT, 4'd0, VAL_MIN);
        send_item(REQ_PUSH_BACK, 4'd0, VAL_NEG_ONE);
        send_item(REQ_PUSH_BACK, 4'd0, 32'd0);
        send_item(REQ_READ, 4'd0, 32'd0);
        send_item(REQ_READ, 4'd3, 32'd0);
        send_item(REQ_READ, 4'd4, 32'd0);
        send_item(REQ_READ, 4'd15, 32'd0);
        send_item(REQ_WRITE, 4'd2, 32'd1);
        send_item(REQ_WRITE, 4'd15, 32'd7);
        send_item(REQ_CONTAINS, 4'd0, VAL_MIN);
        send_item(REQ_CONTAINS, 4'd0, 32'd12345);
        send_item(REQ_GREATER, 4'd0, VAL_MIN);
        send_item(REQ_GREATER, 4'd0, VAL_MAX);
        send_item(REQ_POP_FRONT, 4'd0, 32'd0);
        send_item(REQ_POP_BACK, 4'd0, 32'd0);
        send_item(REQ_CLEAR, 4'd0, 32'd0);
        drain_outcomes();
    endtask

    // An ascending fill puts the first greater entry just inside and just beyond the search limit.
    task automatic test_full_store();
        for (int n = 0; n < DEPTH; n++)
            send_item(REQ_PUSH_BACK, 4'd0, 32'(n * 10));
        send_item(REQ_GREATER, 4'd0, 32'd105);
        send_item(REQ_GREATER, 4'd0, 32'd115);
        send_item(REQ_PUSH_FRONT, 4'd0, 32'd1);
        send_item(REQ_PUSH_BACK, 4'd0, 32'd2);
        send_item(REQ_READ, 4'd15, 32'd0);
        send_item(REQ_WRITE, 4'd15, 32'hFFFF_FFFB);
        send_item(REQ_CONTAINS, 4'd0, 32'hFFFF_FFFB);
        send_item(REQ_CLEAR, 4'd0, 32'd0);
        send_item(REQ_POP_BACK, 4'd0, 32'd0);
        drain_outcomes();
    endtask

    // The result side holds off while requests keep coming, so the input must stall.
    task automatic test_backpressure();
        rx_hold_cycles = 150;
        random_requests(40);
        drain_outcomes();
    endtask

    task automatic test_random_traffic();
        logic [3:0] limits [6];
        limits[0] = 4'd0;
        limits[1] = 4'd15;
        limits[2] = 4'd1;
        limits[3] = GSL_RESET;
        limits[4] = 4'($urandom_range(2, 14));
        limits[5] = 4'($urandom_range(0, 15));
        foreach (limits[p]) begin
            drain_outcomes();
            set_search_limit(limits[p]);
            random_requests(300);
        end
        drain_outcomes();
    endtask

    initial begin : result_sink
        int stall;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_ready = 1'b0;
                repeat (rx_hold_cycles) @(negedge i_clk);
                rx_hold_cycles = 0;
            end
            stall = draw_wait(rx_calm);
            if (stall > 0) begin
                i_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid && rx_hold_cycles == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (outcomes_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result: status %0d data %h count %0d",
                                        o_status, o_data, o_count));
            end else begin
                due = outcomes_due.pop_front();
                if (o_status !== due.status || o_data !== due.data || o_found !== due.found ||
                    o_position !== due.position || o_count !== due.count)
                    flag_mismatch($sformatf(
                        {"expected st %0d data %h fnd %0b pos %0d cnt %0d, ",
                         "got st %0d data %h fnd %0b pos %0d cnt %0d"},
                        due.status, due.data, due.found, due.position, due.count,
                        o_status, o_data, o_found, o_position, o_count));
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_req_type = REQ_PUSH_FRONT;
        i_index    = '0;
        i_value    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = SEARCH_LAST_ADDR;
        pwdata     = '0;
        foreach (shadow_slots[s])
            shadow_slots[s] = '0;
        shadow_front       = '0;
        shadow_fill        = '0;
        shadow_search_last = GSL_RESET;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_store();
        test_mixed_contents();
        test_full_store();
        test_backpressure();
        test_random_traffic();

        drain_outcomes();
        if (outcomes_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));
        if (bad_outcomes == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
